FILE: src/aws_pkg.sv
// Shared types, constants and byte classification for the anagram window search.
// No dependencies; every other file in this block imports it.
package aws_pkg;

   localparam int MAX_PATTERN = 63;
   localparam int POS_BITS    = 24;
   localparam int LETTERS     = 26;
   localparam int PTR_W       = $clog2(MAX_PATTERN);
   localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
   localparam int LETTER_W    = $clog2(LETTERS);

   localparam logic [7:0] CHAR_UPPER_A = 8'd65;
   localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [7:0] CHAR_LOWER_A = 8'd97;
   localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_LAST    = 8'd127;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [PTR_W-1:0]    ptr_type;
   typedef logic [CNT_W-1:0]    count_type;
   typedef logic [POS_BITS-1:0] pos_type;

   localparam pos_type POS_MAX = '1;

   typedef enum logic [1:0] {
      KIND_CLEAR   = 2'd0,
      KIND_PATTERN = 2'd1,
      KIND_TEXT    = 2'd2,
      KIND_END     = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_req;
   } req_type;

   typedef struct packed {
      logic    found;
      pos_type start_offset;
      pos_type end_offset;
      pos_type line_number;
   } rsp_type;

   typedef struct packed {
      letter_type letter;
      pos_type    offset;
      pos_type    line;
   } ring_entry_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } ring_ctl_type;

   typedef struct packed {
      logic       clear_all;
      logic       pat_inc;
      logic       win_add;
      logic       win_drop;
      logic       win_clr;
      letter_type add_code;
      letter_type drop_code;
   } cnt_ctl_type;

   function automatic logic is_letter(input logic [7:0] b);
      return ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ||
             ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z));
   endfunction

   // Fold case: both ranges map onto 0..25.
   function automatic letter_type letter_of(input logic [7:0] b);
      logic [7:0] diff;
      if (b <= CHAR_UPPER_Z) begin
         diff = b - CHAR_UPPER_A;
      end else begin
         diff = b - CHAR_LOWER_A;
      end
      return letter_type'(diff);
   endfunction

   // Printable non-letters only advance the offset.
   function automatic logic is_skipped(input logic [7:0] b);
      return (b >= CHAR_SPACE) && (b <= CHAR_LAST) && !is_letter(b);
   endfunction

endpackage

FILE: src/aws_count_row.sv
// Per-letter pattern and window counts, one cell per letter, with the all-equal test.
// Depends on aws_pkg for the count types and the control struct.
module aws_count_row (
   input  logic                clock,
   input  logic                reset,
   input  aws_pkg::cnt_ctl_type ctl,
   output logic                all_eq
);
   import aws_pkg::*;

   count_type           pat_ff [LETTERS];
   count_type           win_ff [LETTERS];
   count_type           pat_in [LETTERS];
   count_type           win_in [LETTERS];
   logic [LETTERS-1:0]  eq;

   always_comb begin
      for (int i = 0; i < LETTERS; i++) begin
         pat_in[i] = pat_ff[i];
         win_in[i] = win_ff[i];
         if (ctl.clear_all) begin
            pat_in[i] = '0;
            win_in[i] = '0;
         end else begin
            if (ctl.pat_inc && (ctl.add_code == letter_type'(i))) begin
               pat_in[i] = pat_ff[i] + 1'b1;
            end
            if (ctl.win_clr) begin
               win_in[i] = '0;
            end else begin
               win_in[i] = win_ff[i]
                  + count_type'(ctl.win_add && (ctl.add_code == letter_type'(i)))
                  - count_type'(ctl.win_drop && (ctl.drop_code == letter_type'(i)));
            end
         end
         eq[i] = (pat_in[i] == win_in[i]);
      end
   end

   // All letter counts agree when every per-letter compare of the next-state counts holds.
   assign all_eq = &eq;

   always_ff @(posedge clock) begin
      for (int i = 0; i < LETTERS; i++) begin
         if (reset) begin
            pat_ff[i] <= '0;
            win_ff[i] <= '0;
         end else begin
            pat_ff[i] <= pat_in[i];
            win_ff[i] <= win_in[i];
         end
      end
   end

endmodule

FILE: src/aws_ring.sv
// Circular window buffer of letter, offset and line, held in one synchronous memory.
// Depends on aws_pkg; reads ahead the oldest and next-oldest entries with write forwarding.
module aws_ring (
   input  logic                   clock,
   input  logic                   reset,
   input  aws_pkg::ring_ctl_type   ctl,
   input  aws_pkg::ring_entry_type wr_entry,
   output aws_pkg::ring_entry_type oldest,
   output aws_pkg::ring_entry_type second,
   output aws_pkg::count_type      fill
);
   import aws_pkg::*;

   ring_entry_type ring_mem [MAX_PATTERN];

   ptr_type        head_ff, head_in;
   ptr_type        tail_ff, tail_in;
   count_type      fill_ff, fill_in;
   ptr_type        rd_a, rd_b;
   logic           wr_en;
   ring_entry_type oldest_ff, second_ff;

   function automatic ptr_type ptr_inc(input ptr_type p);
      return (p == ptr_type'(MAX_PATTERN - 1)) ? '0 : ptr_type'(p + 1'b1);
   endfunction

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      wr_en   = 1'b0;
      if (ctl.flush) begin
         tail_in = head_ff;
         fill_in = '0;
      end else begin
         if (ctl.pop) begin
            head_in = ptr_inc(head_ff);
         end
         if (ctl.push) begin
            tail_in = ptr_inc(tail_ff);
            wr_en   = 1'b1;
         end
         fill_in = fill_ff + count_type'(ctl.push) - count_type'(ctl.pop);
      end
      rd_a = head_in;
      rd_b = ptr_inc(head_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[tail_ff] <= wr_entry;
      end
   end

   // Forward the entry being written when it lands on a read-ahead address.
   always_ff @(posedge clock) begin
      if (wr_en && (tail_ff == rd_a)) begin
         oldest_ff <= wr_entry;
      end else begin
         oldest_ff <= ring_mem[rd_a];
      end
      if (wr_en && (tail_ff == rd_b)) begin
         second_ff <= wr_entry;
      end else begin
         second_ff <= ring_mem[rd_b];
      end
   end

   assign oldest = oldest_ff;
   assign second = second_ff;
   assign fill   = fill_ff;

endmodule

FILE: src/anagram_window_search_top.sv
// Anagram window search top level: byte classification, position and line tracking, result queue.
// Depends on aws_pkg, aws_count_row and aws_ring.
//
// Load a pattern one letter per transaction, stream text bytes, and the block reports the first
// run of letters that is an anagram of the pattern (case folded) as start offset, end offset and
// start line, or found=0 at end of text. A new transaction is accepted on each clock unless req_stall
// is high, while the window buffer memory reads the oldest entries ahead into registers, with
// forwarding from the write of the same cycle. A result is registered into the output register,
// or into a skid stage behind it while the output is held; the skid stage lets input keep flowing,
// and req_stall rises only while both hold undelivered results. Reset needs no clearing pass.
module anagram_window_search_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  aws_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output aws_pkg::rsp_type rsp_data
);
   import aws_pkg::*;

   logic           accept;
   logic           letter_hit;
   letter_type     code;
   pos_type        pos_ff, pos_in, pos_inc;
   pos_type        line_ff, line_in;
   count_type      plen_ff, plen_in;
   logic           done_ff, done_in;
   count_type      fill;
   count_type      fill_after;
   logic           all_eq;
   ring_entry_type oldest, second, new_entry, start_entry;
   ring_ctl_type   ring_ctl;
   cnt_ctl_type    cnt_ctl;
   logic           result_valid;
   rsp_type        result;

   logic           out_valid_ff, out_valid_in;
   rsp_type        out_ff, out_in;
   logic           skid_valid_ff, skid_valid_in;
   rsp_type        skid_ff, skid_in;
   logic           pop;

   assign accept     = req_valid && !req_stall;
   assign letter_hit = is_letter(req_data.byte_req);
   assign code       = letter_of(req_data.byte_req);
   assign pos_inc    = (pos_ff < POS_MAX) ? pos_ff + 1'b1 : POS_MAX;

   assign new_entry.letter = code;
   assign new_entry.offset = pos_ff;
   assign new_entry.line   = line_ff;

   always_comb begin
      pos_in       = pos_ff;
      line_in      = line_ff;
      plen_in      = plen_ff;
      done_in      = done_ff;
      ring_ctl     = '0;
      cnt_ctl      = '0;
      cnt_ctl.add_code  = code;
      cnt_ctl.drop_code = oldest.letter;
      fill_after   = fill;
      start_entry  = oldest;
      result_valid = 1'b0;
      result       = '0;

      if (accept) begin
         case (req_data.kind)
            KIND_CLEAR: begin
               pos_in            = '0;
               line_in           = pos_type'(1);
               plen_in           = '0;
               done_in           = 1'b0;
               ring_ctl.flush    = 1'b1;
               cnt_ctl.clear_all = 1'b1;
            end
            KIND_PATTERN: begin
               if (letter_hit && !done_ff && (pos_ff == '0) &&
                   (plen_ff < count_type'(MAX_PATTERN))) begin
                  cnt_ctl.pat_inc = 1'b1;
                  plen_in         = plen_ff + 1'b1;
               end
            end
            KIND_TEXT: begin
               if (!done_ff) begin
                  pos_in = pos_inc;
                  if (letter_hit) begin
                     if (plen_ff != '0) begin
                        cnt_ctl.win_add  = 1'b1;
                        ring_ctl.push    = 1'b1;
                        // Full window: retire the oldest letter as this one enters.
                        if (fill >= plen_ff) begin
                           cnt_ctl.win_drop = 1'b1;
                           ring_ctl.pop     = 1'b1;
                        end else begin
                           fill_after = fill + 1'b1;
                        end
                        if (fill_after == count_type'(1)) begin
                           start_entry = new_entry;
                        end else if (ring_ctl.pop) begin
                           start_entry = second;
                        end else begin
                           start_entry = oldest;
                        end
                        if ((fill_after == plen_ff) && all_eq) begin
                           done_in             = 1'b1;
                           result_valid        = 1'b1;
                           result.found        = 1'b1;
                           result.start_offset = start_entry.offset;
                           result.end_offset   = pos_inc;
                           result.line_number  = start_entry.line;
                        end
                     end
                  end else if (!is_skipped(req_data.byte_req)) begin
                     if ((req_data.byte_req == CHAR_NEWLINE) && (line_ff < POS_MAX)) begin
                        line_in = line_ff + 1'b1;
                     end
                     ring_ctl.flush  = 1'b1;
                     cnt_ctl.win_clr = 1'b1;
                  end
               end
            end
            KIND_END: begin
               if (!done_ff) begin
                  done_in      = 1'b1;
                  result_valid = 1'b1;
               end
            end
            default: begin
               done_in = done_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         line_ff <= pos_type'(1);
         plen_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         line_ff <= line_in;
         plen_ff <= plen_in;
         done_ff <= done_in;
      end
   end

   aws_count_row u_count_row (
      .clock  (clock),
      .reset  (reset),
      .ctl    (cnt_ctl),
      .all_eq (all_eq)
   );

   aws_ring u_ring (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ring_ctl),
      .wr_entry (new_entry),
      .oldest   (oldest),
      .second   (second),
      .fill     (fill)
   );

   // Output register plus skid stage.
   assign pop       = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (result_valid) begin
         if (!out_valid_ff || pop) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a transaction while the output register is empty");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      result_valid |=> done_ff)
      else $error("search not closed after a result");

   a_no_result_when_done: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> !done_ff)
      else $error("result produced after the search closed");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill <= plen_ff)
      else $error("window holds more letters than the pattern");
`endif

endmodule

FILE: test/aws_match_checker.sv
// Scoreboard for the anagram window search: watches both channels, predicts each span result.
// Depends on aws_pkg for the transaction types, kind codes and byte constants.
module aws_match_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  aws_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  aws_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               span_backlog
);
   timeunit 1ns;
   timeprecision 1ps;
   import aws_pkg::*;

   count_type  pat_count [LETTERS];
   count_type  win_count [LETTERS];
   count_type  pat_len;
   count_type  win_fill;
   logic [6:0] miss_total;
   letter_type ring_letter [MAX_PATTERN];
   pos_type    ring_offset [MAX_PATTERN];
   pos_type    ring_line [MAX_PATTERN];
   pos_type    text_pos;
   pos_type    line_cnt;
   logic       finished;

   rsp_type pending_spans[$];
   int      fail_total = 0;

   function automatic void clear_search();
      for (int i = 0; i < LETTERS; i++) begin
         pat_count[i] = '0;
         win_count[i] = '0;
      end
      for (int i = 0; i < MAX_PATTERN; i++) begin
         ring_letter[i] = '0;
         ring_offset[i] = '0;
         ring_line[i]   = '0;
      end
      pat_len    = '0;
      win_fill   = '0;
      miss_total = '0;
      text_pos   = '0;
      line_cnt   = pos_type'(1);
      finished   = 1'b0;
   endfunction

   // Retire the oldest letter of the window and shift the rings down.
   function automatic void slide_out();
      letter_type c;
      c = ring_letter[0];
      if (win_count[c] > pat_count[c]) begin
         miss_total = miss_total - 1'b1;
      end else begin
         miss_total = miss_total + 1'b1;
      end
      if (win_count[c] != 0) begin
         win_count[c] = win_count[c] - 1'b1;
      end
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
         ring_letter[i] = ring_letter[i+1];
         ring_offset[i] = ring_offset[i+1];
         ring_line[i]   = ring_line[i+1];
      end
      win_fill = win_fill - 1'b1;
   endfunction

   function automatic void slide_in(letter_type c, pos_type off);
      if (win_count[c] < pat_count[c]) begin
         miss_total = miss_total - 1'b1;
      end else begin
         miss_total = miss_total + 1'b1;
      end
      win_count[c]          = win_count[c] + 1'b1;
      ring_letter[win_fill] = c;
      ring_offset[win_fill] = off;
      ring_line[win_fill]   = line_cnt;
      win_fill              = win_fill + 1'b1;
   endfunction

   function automatic void predict_span(req_type r);
      logic [7:0] b;
      logic       alpha;
      letter_type code;
      pos_type    off;
      rsp_type    span;
      b     = r.byte_req;
      alpha = ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ||
              ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z));
      // Both letter ranges start at 1 in the low five bits.
      code  = letter_type'(b[4:0] - 5'd1);
      span  = '0;
      case (r.kind)
         KIND_CLEAR: begin
            clear_search();
         end
         KIND_PATTERN: begin
            if (alpha && !finished && text_pos == 0 && pat_len < MAX_PATTERN) begin
               pat_count[code] = pat_count[code] + 1'b1;
               pat_len         = pat_len + 1'b1;
               miss_total      = miss_total + 1'b1;
            end
         end
         KIND_END: begin
            if (!finished) begin
               finished = 1'b1;
               pending_spans.push_back(span);
            end
         end
         KIND_TEXT: begin
            if (!finished) begin
               off = text_pos;
               if (text_pos != POS_MAX) text_pos = text_pos + 1'b1;
               if (alpha) begin
                  if (pat_len != 0) begin
                     if (win_fill >= pat_len) slide_out();
                     slide_in(code, off);
                     if (win_fill == pat_len && miss_total == 0) begin
                        finished          = 1'b1;
                        span.found        = 1'b1;
                        span.start_offset = ring_offset[0];
                        span.end_offset   = (off != POS_MAX) ? off + 1'b1 : POS_MAX;
                        span.line_number  = ring_line[0];
                        pending_spans.push_back(span);
                     end
                  end
               end else if (b < CHAR_SPACE || b > CHAR_LAST) begin
                  if (b == CHAR_NEWLINE && line_cnt != POS_MAX) line_cnt = line_cnt + 1'b1;
                  // Control and high bytes empty the window.
                  for (int i = 0; i < LETTERS; i++) win_count[i] = '0;
                  win_fill   = '0;
                  miss_total = 7'(pat_len);
               end
            end
         end
      endcase
   endfunction

   function automatic void check_field(string name, logic [POS_BITS-1:0] want,
                                       logic [POS_BITS-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_total++;
      end
   endfunction

   function automatic void check_span(rsp_type got);
      rsp_type want;
      if (pending_spans.size() == 0) begin
         $error("result with no transaction waiting: found %0d start %0d end %0d line %0d",
                got.found, got.start_offset, got.end_offset, got.line_number);
         fail_total++;
      end else begin
         want = pending_spans.pop_front();
         check_field("found", POS_BITS'(want.found), POS_BITS'(got.found));
         check_field("start_offset", want.start_offset, got.start_offset);
         check_field("end_offset", want.end_offset, got.end_offset);
         check_field("line_number", want.line_number, got.line_number);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_search();
         pending_spans.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_span(rsp_data);
         if (req_valid && !req_stall) predict_span(req_data);
      end
      mismatch_count <= fail_total;
      span_backlog   <= pending_spans.size();
   end

endmodule

FILE: test/tb_anagram_window_search_top.sv
// Testbench top for the anagram window search: clock, reset, stimulus, stalls and verdict.
// Depends on aws_pkg, the block under test and aws_match_checker.
module tb_anagram_window_search_top;
   timeunit 1ns;
   timeprecision 1ps;
   import aws_pkg::*;

   localparam int ITEM_TARGET = 840;
   localparam int IDLE_LIMIT  = 5000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int mismatch_count;
   int span_backlog;
   int items_sent = 0;
   int stall_hold = 0;
   bit steady     = 1'b0;
   int pattern_letters[$];

   anagram_window_search_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   aws_match_checker match_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .span_backlog   (span_backlog)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones; none during a steady stretch.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_stall  <= !steady && ($urandom_range(0, 2) == 0);
         stall_hold <= idle_len();
      end
   end

   function automatic logic [7:0] cased_letter(int l);
      if ($urandom_range(0, 1) != 0) return CHAR_UPPER_A + 8'(l);
      return CHAR_LOWER_A + 8'(l);
   endfunction

   function automatic logic [7:0] skipped_byte();
      case ($urandom_range(0, 2))
         0:       return 8'($urandom_range(32, 64));
         1:       return 8'($urandom_range(91, 96));
         default: return 8'($urandom_range(123, 127));
      endcase
   endfunction

   function automatic logic [7:0] noise_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return cased_letter($urandom_range(0, 25));
      if (r < 65) return skipped_byte();
      if (r < 75) return CHAR_NEWLINE;
      if (r < 85) return 8'($urandom_range(0, 31));
      if (r < 92) return 8'($urandom_range(128, 255));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_item(kind_type k, logic [7:0] b);
      int gap;
      gap = idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{kind: k, byte_req: b};
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Hold the sender until every predicted result has been delivered.
   task automatic drain_spans();
      req_valid <= 1'b0;
      do @(posedge clock); while (span_backlog != 0);
   endtask

   task automatic send_noise(int n);
      repeat (n) send_item(KIND_TEXT, noise_byte());
   endtask

   task automatic load_pattern(int n);
      int l;
      pattern_letters.delete();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(KIND_PATTERN, ($urandom_range(0, 1) != 0) ? skipped_byte()
                                                                : 8'($urandom_range(128, 255)));
         end
         l = $urandom_range(0, 25);
         pattern_letters.push_back(l);
         send_item(KIND_PATTERN, cased_letter(l));
      end
   endtask

   // Permute the loaded pattern and send it, with the odd skipped byte inside the run.
   task automatic send_anagram();
      int order[$];
      int j;
      int t;
      order = pattern_letters;
      for (int i = order.size() - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      foreach (order[i]) begin
         if ($urandom_range(0, 99) < 15) send_item(KIND_TEXT, skipped_byte());
         send_item(KIND_TEXT, cased_letter(order[i]));
      end
   endtask

   task automatic run_sequence();
      int r;
      int plen;
      steady = ($urandom_range(0, 99) < 15);
      if ($urandom_range(0, 99) < 10) begin
         repeat ($urandom_range(1, 10)) begin
            send_item(kind_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end
      end else begin
         send_item(KIND_CLEAR, 8'($urandom_range(0, 255)));
         r = $urandom_range(0, 99);
         if (r < 85)      plen = $urandom_range(1, 6);
         else if (r < 94) plen = $urandom_range(7, 20);
         else if (r < 98) plen = $urandom_range(60, 70);
         else             plen = 0;
         load_pattern(plen);
         send_noise($urandom_range(0, 10));
         if ($urandom_range(0, 99) < 75) send_anagram();
         if ($urandom_range(0, 9) == 0) send_item(KIND_PATTERN, cased_letter($urandom_range(0, 25)));
         send_noise($urandom_range(0, 6));
         if ($urandom_range(0, 9) != 0) send_item(KIND_END, 8'($urandom_range(0, 255)));
         // Text after the result has been decided is dropped by the block.
         if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 4));
      end
      if ($urandom_range(0, 9) == 0) drain_spans();
   endtask

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty pattern: end of text reports no match, later text is dropped.
      send_item(KIND_END, 8'hFF);
      send_item(KIND_TEXT, "a");

      // Pattern "abz" with folded capitals and an ignored symbol.
      send_item(KIND_CLEAR, 8'h00);
      send_item(KIND_PATTERN, "A");
      send_item(KIND_PATTERN, "#");
      send_item(KIND_PATTERN, "b");
      send_item(KIND_PATTERN, "Z");
      send_item(KIND_TEXT, CHAR_NEWLINE);
      send_item(KIND_PATTERN, "q");
      send_item(KIND_TEXT, "z");
      send_item(KIND_TEXT, 8'h00);
      send_item(KIND_TEXT, "y");
      send_item(KIND_TEXT, 8'hFF);
      send_item(KIND_TEXT, "b");
      send_item(KIND_TEXT, 8'h7F);
      send_item(KIND_TEXT, " ");
      send_item(KIND_TEXT, "a");
      send_item(KIND_TEXT, "Z");
      send_item(KIND_END, 8'h00);

      // Repeated letter: the window has to slide past a wrong one.
      send_item(KIND_CLEAR, 8'hFF);
      send_item(KIND_PATTERN, "a");
      send_item(KIND_PATTERN, "A");
      send_item(KIND_TEXT, "a");
      send_item(KIND_TEXT, "b");
      send_item(KIND_TEXT, "a");
      send_item(KIND_TEXT, "A");
      drain_spans();

      while (items_sent < ITEM_TARGET) run_sequence();

      steady = 1'b0;
      drain_spans();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && span_backlog == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/aws_pkg.sv
src/aws_count_row.sv
src/aws_ring.sv
src/anagram_window_search_top.sv
test/aws_match_checker.sv
test/tb_anagram_window_search_top.sv
